// ===== rtl/ryla_pkg.sv =====
// Shared types, coefficients and clamp helpers for the RGB/YUV luma adjust pipeline.
package ryla_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_ADJUST_MODE = 8'd0;
    localparam logic [7:0] REG_LUMA_GAIN   = 8'd1;

    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth  = 10;
    localparam int GainWidth     = 10;

    // Reset values of the configuration registers
    localparam logic             ADJUST_MODE_RESET = 1'b1;
    localparam logic [GainWidth-1:0] LUMA_GAIN_RESET = 10'd256;

    // Forward transform, Q12 magnitudes (sign applied in the sums)
    localparam logic [11:0] C_YR = 12'd1221;
    localparam logic [11:0] C_YG = 12'd2507;
    localparam logic [11:0] C_YB = 12'd479;
    localparam logic [11:0] C_UR = 12'd688;
    localparam logic [11:0] C_UG = 12'd1352;
    localparam logic [11:0] C_UB = 12'd2040;
    localparam logic [11:0] C_VR = 12'd1839;
    localparam logic [11:0] C_VG = 12'd1782;
    localparam logic [11:0] C_VB = 12'd340;

    // Inverse transform, Q12 magnitudes
    localparam logic [12:0] C_RV = 13'd5765;
    localparam logic [12:0] C_GU = 13'd1415;
    localparam logic [12:0] C_GV = 13'd2936;
    localparam logic [12:0] C_BU = 13'd7287;

    // Chroma offset of 128 in Q12
    localparam logic signed [22:0] CHROMA_OFFSET_Q12 = 23'sd524288;
    localparam logic [7:0]         CHROMA_MID        = 8'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb       rgb;
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } t_yuv_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] gray;
    } t_pixel_out;

    // Drop the Q12 fraction and saturate to a byte; negative sums give zero
    function automatic logic [7:0] clamp_q12(input logic signed [22:0] sum);
        logic [7:0] res;
        if (sum[22]) begin
            res = 8'd0;
        end else if (sum[21:20] != 2'd0) begin
            res = 8'hFF;
        end else begin
            res = sum[19:12];
        end
        return res;
    endfunction

    // Drop the 8-bit fraction of the Q10.8 scaled luma and saturate to a byte
    function automatic logic [7:0] clamp_q8(input logic [17:0] prod);
        logic [7:0] res;
        if (prod[17:16] != 2'd0) begin
            res = 8'hFF;
        end else begin
            res = prod[15:8];
        end
        return res;
    endfunction

endpackage

// ===== rtl/ryla_rgb2yuv.sv =====
// Two-stage forward transform: constant products, then sums with clamp to Y, U, V.
module ryla_rgb2yuv
    import ryla_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_rgb      i_rgb,
    output logic      o_valid,
    input  logic      i_ready,
    output t_yuv_item o_item
);

    logic       r_v1, r_v2;
    logic       rdy1, rdy2;
    t_rgb       r_rgb1;
    logic [19:0] r_yr, r_yg, r_yb, r_ur, r_ug, r_ub, r_vr, r_vg, r_vb;
    t_yuv_item  r_item2;

    logic signed [22:0] y_sum, u_sum, v_sum;

    // Each stage moves when it is empty or its successor moves
    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // Valid bits for stages 1 and 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage 1: coefficient products
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_rgb1 <= i_rgb;
            r_yr   <= 20'(i_rgb.red)   * 20'(C_YR);
            r_yg   <= 20'(i_rgb.green) * 20'(C_YG);
            r_yb   <= 20'(i_rgb.blue)  * 20'(C_YB);
            r_ur   <= 20'(i_rgb.red)   * 20'(C_UR);
            r_ug   <= 20'(i_rgb.green) * 20'(C_UG);
            r_ub   <= 20'(i_rgb.blue)  * 20'(C_UB);
            r_vr   <= 20'(i_rgb.red)   * 20'(C_VR);
            r_vg   <= 20'(i_rgb.green) * 20'(C_VG);
            r_vb   <= 20'(i_rgb.blue)  * 20'(C_VB);
        end
    end

    // Stage 2: signed sums of the products
    always_comb begin
        y_sum = $signed({3'b000, r_yr}) + $signed({3'b000, r_yg})
              + $signed({3'b000, r_yb});
        u_sum = $signed({3'b000, r_ub}) - $signed({3'b000, r_ur})
              - $signed({3'b000, r_ug}) + CHROMA_OFFSET_Q12;
        v_sum = $signed({3'b000, r_vr}) - $signed({3'b000, r_vg})
              - $signed({3'b000, r_vb}) + CHROMA_OFFSET_Q12;
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_item2.rgb <= r_rgb1;
            r_item2.y   <= clamp_q12(y_sum);
            r_item2.u   <= clamp_q12(u_sum);
            r_item2.v   <= clamp_q12(v_sum);
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_item2;

endmodule

// ===== rtl/ryla_yuv2rgb.sv =====
// Two-stage inverse transform: luma gain and chroma products, then sums, clamp and mode select.
module ryla_yuv2rgb
    import ryla_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_yuv_item            i_item,
    input  logic                 i_adjust_mode,
    input  logic [GainWidth-1:0] i_luma_gain,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_pixel_out           o_pixel
);

    logic        r_v3, r_v4;
    logic        rdy3, rdy4;
    t_rgb        r_rgb3;
    logic [7:0]  r_y3;
    logic [17:0] r_ys_prod;
    logic signed [22:0] r_rv, r_gu, r_gv, r_bu;
    t_pixel_out  r_pix4;

    logic signed [8:0]  du, dv;
    logic signed [22:0] du_x, dv_x;
    logic [7:0]         ys;
    logic signed [22:0] base, r_sum, g_sum, b_sum;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;

    // Valid bits for stages 3 and 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy3) begin
                r_v3 <= i_valid;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Center the chroma around zero
    always_comb begin
        du   = $signed({1'b0, i_item.u}) - $signed({1'b0, CHROMA_MID});
        dv   = $signed({1'b0, i_item.v}) - $signed({1'b0, CHROMA_MID});
        du_x = 23'(du);
        dv_x = 23'(dv);
    end

    // Stage 3: luma gain and chroma products
    always_ff @(posedge i_clk) begin
        if (rdy3 && i_valid) begin
            r_rgb3    <= i_item.rgb;
            r_y3      <= i_item.y;
            r_ys_prod <= 18'(i_item.y) * 18'(i_luma_gain);
            r_rv      <= dv_x * $signed({10'd0, C_RV});
            r_gu      <= du_x * $signed({10'd0, C_GU});
            r_gv      <= dv_x * $signed({10'd0, C_GV});
            r_bu      <= du_x * $signed({10'd0, C_BU});
        end
    end

    // Stage 4: add the scaled luma back in
    always_comb begin
        ys    = clamp_q8(r_ys_prod);
        base  = $signed({3'b000, ys, 12'd0});
        r_sum = base + r_rv;
        g_sum = base - r_gu - r_gv;
        b_sum = base + r_bu;
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_pix4.gray <= r_y3;
            if (i_adjust_mode) begin
                r_pix4.red   <= clamp_q12(r_sum);
                r_pix4.green <= clamp_q12(g_sum);
                r_pix4.blue  <= clamp_q12(b_sum);
            end else begin
                r_pix4.red   <= r_rgb3.red;
                r_pix4.green <= r_rgb3.green;
                r_pix4.blue  <= r_rgb3.blue;
            end
        end
    end

    assign o_valid = r_v4;
    assign o_pixel = r_pix4;

endmodule

// ===== rtl/rgb_yuv_luma_adjust_unit.sv =====
// Top level: stream ports, configuration registers and the four-stage pixel pipeline.
// One RGB pixel enters per clock and leaves as an adjusted RGB pixel plus its luma as
// gray after four register stages (forward products, forward sums and clamp, gain and
// inverse products, inverse sums and clamp), and the sustained rate is one pixel per
// clock while the output side accepts. When the output stalls, empty stages still fill,
// so up to four pixels are held in flight. Write the adjust mode (index 0) and luma
// gain (index 1, Q2.8) only while no pixel is in flight; writes to other indexes are
// ignored.
module rgb_yuv_luma_adjust_unit
    import ryla_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Pixel input
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [23:0]              i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // Pixel output
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [31:0]              o_m_tdata,   // red[7:0], green[15:8], blue[23:16],
                                                  // gray[31:24]
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_data
);

    logic                 r_adjust_mode;
    logic [GainWidth-1:0] r_luma_gain;

    t_rgb       in_rgb;
    t_yuv_item  mid_item;
    logic       mid_valid, mid_ready;
    t_pixel_out out_pix;

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adjust_mode <= ADJUST_MODE_RESET;
            r_luma_gain   <= LUMA_GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ADJUST_MODE: r_adjust_mode <= i_cfg_data[0];
                REG_LUMA_GAIN:   r_luma_gain   <= i_cfg_data[GainWidth-1:0];
                default:         ;
            endcase
        end
    end

    // Unpack the input transaction
    assign in_rgb.red   = i_s_tdata[7:0];
    assign in_rgb.green = i_s_tdata[15:8];
    assign in_rgb.blue  = i_s_tdata[23:16];

    ryla_rgb2yuv u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_rgb   (in_rgb),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_item  (mid_item)
    );

    ryla_yuv2rgb u_inv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mid_valid),
        .o_ready       (mid_ready),
        .i_item        (mid_item),
        .i_adjust_mode (r_adjust_mode),
        .i_luma_gain   (r_luma_gain),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_pixel       (out_pix)
    );

    // Pack the output transaction
    assign o_m_tdata = {out_pix.gray, out_pix.blue, out_pix.green, out_pix.red};

    // An empty output stage means every stage can move, so input must be open
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked while output stage is empty");

    // Nothing comes out right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    // A stalled mid-pipeline handoff implies the downstream half is full
    a_mid_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mid_valid && !mid_ready) |-> (o_m_tvalid && !i_m_tready))
        else $error("mid-pipeline stall without output stall");

endmodule

// ===== verif/tb.sv =====
// Testbench for rgb_yuv_luma_adjust_unit: predicts each pixel result and checks the stream.
`timescale 1ns / 1ps

module tb;
    import ryla_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int DrainCycles  = 8;
    localparam int IdlePercent  = 37;
    localparam int RandPhases   = 8;
    localparam int PhasePixels  = 128;

    // Expected pixel results plus a private copy of the two registers
    class luma_pixel_board;
        bit              mode_adjust;
        bit [9:0]        gain_q8;
        t_pixel_out      awaited_pixels[$];
        int              mismatches;

        function new();
            mode_adjust = 1'b1;
            gain_q8     = 10'd256;
            mismatches  = 0;
        endfunction

        // Track a register write the same way the block decodes it
        function void note_config(logic [7:0] idx, logic [9:0] data);
            if (idx == REG_ADJUST_MODE) begin
                mode_adjust = data[0];
            end else if (idx == REG_LUMA_GAIN) begin
                gain_q8 = data;
            end
        endfunction

        // Truncate a Q12 sum to a byte, negative gives zero, overflow saturates
        function int q12_to_byte(int sum);
            int v;
            if (sum < 0) begin
                return 0;
            end
            v = sum >>> 12;
            return (v > 255) ? 255 : v;
        endfunction

        function t_pixel_out convert_pixel(t_rgb px);
            t_pixel_out res;
            int r, g, b, y, u, v, ys, du, dv, base;
            r = px.red;
            g = px.green;
            b = px.blue;
            y = q12_to_byte(1221 * r + 2507 * g + 479 * b);
            u = q12_to_byte(-688 * r - 1352 * g + 2040 * b + 128 * 4096);
            v = q12_to_byte(1839 * r - 1782 * g - 340 * b + 128 * 4096);
            res.gray = y[7:0];
            if (!mode_adjust) begin
                res.red   = px.red;
                res.green = px.green;
                res.blue  = px.blue;
                return res;
            end
            ys = (y * int'(gain_q8)) >>> 8;
            if (ys > 255) begin
                ys = 255;
            end
            du   = u - 128;
            dv   = v - 128;
            base = ys * 4096;
            res.red   = 8'(q12_to_byte(base + 5765 * dv));
            res.green = 8'(q12_to_byte(base - 1415 * du - 2936 * dv));
            res.blue  = 8'(q12_to_byte(base + 7287 * du));
            return res;
        endfunction

        function void note_pixel(t_rgb px);
            awaited_pixels.push_back(convert_pixel(px));
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction

        task log_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_pixel(t_pixel_out got);
            t_pixel_out want;
            if (awaited_pixels.size() == 0) begin
                log_mismatch($sformatf("unexpected pixel %h", got));
                return;
            end
            want = awaited_pixels.pop_front();
            if (got.red != want.red)
                log_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
            if (got.green != want.green)
                log_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
            if (got.blue != want.blue)
                log_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
            if (got.gray != want.gray)
                log_mismatch($sformatf("gray %0d, want %0d", got.gray, want.gray));
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [23:0]              i_s_tdata;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [31:0]              o_m_tdata;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CfgIndexWidth-1:0] i_cfg_index;
    logic [CfgDataWidth-1:0]  i_cfg_data;

    luma_pixel_board board;
    bit              steady_flow;
    int              cycles;

    rgb_yuv_luma_adjust_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Bound the run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the output side at random outside the steady stretch
    always @(negedge i_clk) begin
        i_m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= IdlePercent);
    end

    // Check every output transaction
    always @(posedge i_clk) begin
        t_pixel_out got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.red   = o_m_tdata[7:0];
            got.green = o_m_tdata[15:8];
            got.blue  = o_m_tdata[23:16];
            got.gray  = o_m_tdata[31:24];
            board.check_pixel(got);
        end
    end

    // Starts and ends at a falling edge
    task automatic send_pixel(input t_rgb px);
        while (!steady_flow && $urandom_range(99) < IdlePercent) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {px.blue, px.green, px.red};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_rgb px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        send_pixel(px);
    endtask

    // Hold the input until every pending result is out and the pipe is empty
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [9:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.note_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] rand_channel();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0) return 8'd0;
        if (sel == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    function automatic logic [9:0] rand_gain();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return 10'd0;
        if (sel == 1) return 10'd1023;
        if (sel == 2) return 10'd256;
        return 10'($urandom);
    endfunction

    initial begin
        logic [9:0] mode_word;
        board       = new();
        cycles      = 0;
        steady_flow = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: black, white (luma overflow), primaries, cyan (negative V), magenta, yellow, mid gray
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd255, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd255);
        send_rgb(8'd0, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd255);
        send_rgb(8'd255, 8'd255, 8'd0);
        send_rgb(8'd128, 8'd128, 8'd128);

        // Maximum gain: scaled luma saturates, output channels overflow
        wait_drained();
        write_reg(REG_LUMA_GAIN, 10'd1023);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd0, 8'd0, 8'd255);
        send_rgb(8'd200, 8'd30, 8'd60);

        // Zero gain: output channels driven negative and clamped
        wait_drained();
        write_reg(REG_LUMA_GAIN, 10'd0);
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd255);
        send_rgb(8'd0, 8'd255, 8'd0);

        // Pass mode through a wide write, plus a write to an unused index
        wait_drained();
        write_reg(REG_ADJUST_MODE, 10'h3FE);
        write_reg(8'hFF, 10'h3FF);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd0, 8'd255, 8'd255);
        send_rgb(8'd17, 8'd99, 8'd201);

        // Back to adjust mode at unity gain
        wait_drained();
        write_reg(REG_ADJUST_MODE, 10'h001);
        write_reg(REG_LUMA_GAIN, 10'd256);
        send_rgb(8'd77, 8'd150, 8'd29);

        // Random phases, each under its own settings
        for (int ph = 0; ph < RandPhases; ph++) begin
            wait_drained();
            mode_word = 10'($urandom);
            case (ph)
                0: mode_word[0] = 1'b1;
                1: mode_word[0] = 1'b0;
                2: mode_word[0] = 1'b1;
                default: mode_word[0] = ($urandom_range(3) != 0);
            endcase
            write_reg(REG_ADJUST_MODE, mode_word);
            case (ph)
                0: write_reg(REG_LUMA_GAIN, 10'd1023);
                2: write_reg(REG_LUMA_GAIN, 10'd0);
                default: write_reg(REG_LUMA_GAIN, rand_gain());
            endcase
            if ($urandom_range(1) == 1) begin
                write_reg(8'($urandom_range(255, 2)), 10'($urandom));
            end
            steady_flow = (ph == 3);
            for (int n = 0; n < PhasePixels; n++) begin
                if (ph == 5 && n == PhasePixels / 2) begin
                    wait_drained();
                end
                send_rgb(rand_channel(), rand_channel(), rand_channel());
            end
            steady_flow = 1'b0;
        end

        // Let the last results out
        i_s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (board.pending() != 0) begin
            board.log_mismatch("pixel results still awaited at the end");
        end
        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ryla_pkg.sv
rtl/ryla_rgb2yuv.sv
rtl/ryla_yuv2rgb.sv
rtl/rgb_yuv_luma_adjust_unit.sv
verif/tb.sv
